>>> rtl/core/ldd_pkg.sv
// Shared types and constants for the ladder button decoder.
package ldd_pkg;

	localparam int SUM_W = 14;
	localparam int AVG_W = 10;
	localparam int LVL_W = 14;
	localparam int MASK_W = 5;
	localparam int TIME_W = 32;
	localparam int SAMPLE_W = 10;
	localparam int WEIGHT_W = 10;
	localparam int TOL_W = 6;
	localparam int DEB_W = 16;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_WEIGHTS = 5;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WEIGHT_0 = 3'd0,
		REG_WEIGHT_1 = 3'd1,
		REG_WEIGHT_2 = 3'd2,
		REG_WEIGHT_3 = 3'd3,
		REG_WEIGHT_4 = 3'd4,
		REG_TOLERANCE = 3'd5,
		REG_DEBOUNCE = 3'd6
	} ldd_reg_t;

	typedef logic [WEIGHT_W-1:0] ldd_weight_t;

	localparam ldd_weight_t WEIGHT_RESET [NUM_WEIGHTS] = '{
		WEIGHT_W'(35), WEIGHT_W'(67), WEIGHT_W'(132), WEIGHT_W'(258), WEIGHT_W'(500)
	};
	localparam logic [TOL_W-1:0] TOLERANCE_RESET = TOL_W'(6);
	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(50);

	// Data that travels along the chain of cells with one group.
	typedef struct packed {
		logic signed [LVL_W-1:0] level;
		logic [TIME_W-1:0] now;
		logic [MASK_W-1:0] held;
		logic [MASK_W-1:0] pressed;
		logic [MASK_W-1:0] released;
	} ldd_flow_t;

endpackage

>>> rtl/core/ladder_button_decode_debounce.sv
// Top level of the resistor-ladder button decoder with debounce.
//
// Input channel in_valid/in_ready carries one ADC reading (adc_sample) with its
// millisecond timestamp (now_ms). Readings are summed in groups of GROUP_SIZE;
// the reading that closes a group supplies the group's timestamp. Each group
// gives one item on out_valid/out_ready with the debounced held mask and the
// pressed and released masks; other readings give no item.
// From the closing reading to its result a group passes the sum stage, the
// reciprocal multiply stage, then the button cells in order, each cell decoding
// and debouncing its own button. Throughput is one reading per cycle while the
// receiver takes results, also when every reading closes a group.
// Readings that do not close a group are always taken; a closing reading waits
// only when the first stage is full and cannot move on.
// When the receiver stalls, groups pile up in the sum, average and cell stages,
// one per stage, and the result stays on the output until taken.
// Reset clears the sum, count, button states and stamps and loads the default
// weights, tolerance and debounce time. The user must write the registers via
// write_en/write_index/write_data only while idle; the block does not check it.
module ladder_button_decode_debounce #(
	parameter int BUTTON_COUNT = 5,
	parameter int GROUP_SIZE = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic write_en,
	input  logic [ldd_pkg::REG_IDX_W-1:0] write_index,
	input  logic [ldd_pkg::CFG_DATA_W-1:0] write_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [ldd_pkg::SAMPLE_W-1:0] adc_sample,
	input  logic [ldd_pkg::TIME_W-1:0] now_ms,
	output logic out_valid,
	input  logic out_ready,
	output logic [ldd_pkg::MASK_W-1:0] held_mask,
	output logic [ldd_pkg::MASK_W-1:0] pressed_mask,
	output logic [ldd_pkg::MASK_W-1:0] released_mask
);
	import ldd_pkg::*;

	ldd_weight_t weight_q [NUM_WEIGHTS];
	logic [TOL_W-1:0] tolerance_q;
	logic [DEB_W-1:0] debounce_q;

	logic chain_valid [BUTTON_COUNT+1];
	logic chain_ready [BUTTON_COUNT+1];
	ldd_flow_t chain_flow [BUTTON_COUNT+1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
			tolerance_q <= TOLERANCE_RESET;
			debounce_q <= DEBOUNCE_RESET;
		end else if (write_en) begin
			unique case (write_index) inside
				REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3, REG_WEIGHT_4: begin
					weight_q[write_index] <= write_data[WEIGHT_W-1:0];
				end
				REG_TOLERANCE: begin
					tolerance_q <= write_data[TOL_W-1:0];
				end
				REG_DEBOUNCE: begin
					debounce_q <= write_data[DEB_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Group sum and average.
	ldd_avg #(
		.GROUP_SIZE(GROUP_SIZE)
	) u_avg (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adc_sample(adc_sample),
		.now_ms(now_ms),
		.out_valid(chain_valid[0]),
		.out_ready(chain_ready[0]),
		.out_flow(chain_flow[0])
	);

	// Chain of button cells, highest button first.
	for (genvar k = 0; k < BUTTON_COUNT; k++) begin : g_cell
		ldd_cell #(
			.BIT(BUTTON_COUNT - 1 - k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.weight(weight_q[BUTTON_COUNT - 1 - k]),
			.tolerance(tolerance_q),
			.debounce_ms(debounce_q),
			.in_valid(chain_valid[k]),
			.in_ready(chain_ready[k]),
			.in_flow(chain_flow[k]),
			.out_valid(chain_valid[k+1]),
			.out_ready(chain_ready[k+1]),
			.out_flow(chain_flow[k+1])
		);
	end

	assign out_valid = chain_valid[BUTTON_COUNT];
	assign chain_ready[BUTTON_COUNT] = out_ready;
	assign held_mask = chain_flow[BUTTON_COUNT].held;
	assign pressed_mask = chain_flow[BUTTON_COUNT].pressed;
	assign released_mask = chain_flow[BUTTON_COUNT].released;

	// A button cannot be both pressed and released in one group.
	a_press_release_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((pressed_mask & released_mask) == '0))
		else $error("button reported pressed and released in the same group");

	// Edge masks agree with the held mask.
	a_edges_match_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((pressed_mask & ~held_mask) == '0)
			&& ((released_mask & held_mask) == '0)))
		else $error("edge mask disagrees with held mask");

	// No bits beyond the configured number of buttons.
	a_unused_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((held_mask | pressed_mask | released_mask) >> BUTTON_COUNT) == '0))
		else $error("mask bit set above button count");

	// A result that was pressed at one group cannot be pressed again at the next.
	a_no_double_press: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> (!out_valid
			|| ((pressed_mask & $past(held_mask)) == '0)
			|| ($past(out_valid) && !$past(out_ready))))
		else $error("button pressed again while already held");

endmodule

>>> rtl/core/ldd_avg.sv
// Sample accumulator and group average by reciprocal multiplication.
module ldd_avg #(
	parameter int GROUP_SIZE = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [ldd_pkg::SAMPLE_W-1:0] adc_sample,
	input  logic [ldd_pkg::TIME_W-1:0] now_ms,
	output logic out_valid,
	input  logic out_ready,
	output ldd_pkg::ldd_flow_t out_flow
);
	import ldd_pkg::*;

	localparam int CNT_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam int SHIFT = SUM_W + $clog2(GROUP_SIZE);
	localparam logic [SHIFT:0] RECIP = (SHIFT+1)'(((1 << SHIFT) + GROUP_SIZE - 1) / GROUP_SIZE);
	localparam int PROD_W = SUM_W + SHIFT + 1;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic last;
	logic take;
	logic [SUM_W-1:0] sum_next;

	logic valid_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [TIME_W-1:0] now_s1;
	logic ready_s1;

	logic valid_s2;
	logic [AVG_W-1:0] avg_s2;
	logic [TIME_W-1:0] now_s2;
	logic ready_s2;

	logic [PROD_W-1:0] product;

	// An item that closes a group needs room in the first stage; others never wait.
	assign last = (count_q == CNT_W'(GROUP_SIZE - 1));
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = !last || ready_s1;
	assign take = in_valid && in_ready;
	assign sum_next = sum_q + SUM_W'(adc_sample);

	// Running sum and sample count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
		end else if (take) begin
			if (last) begin
				sum_q <= '0;
				count_q <= '0;
			end else begin
				sum_q <= sum_next;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// First stage holds the completed group sum and its timestamp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take && last) begin
			valid_s1 <= 1'b1;
		end else if (ready_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			sum_s1 <= sum_next;
			now_s1 <= now_ms;
		end
	end

	// Truncating division by the group size as a multiply by a rounded-up reciprocal.
	assign product = PROD_W'(sum_s1) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (valid_s1 && ready_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			avg_s2 <= product[SHIFT +: AVG_W];
			now_s2 <= now_s1;
		end
	end

	assign out_valid = valid_s2;

	always_comb begin
		out_flow = '0;
		out_flow.level = $signed({{(LVL_W-AVG_W){1'b0}}, avg_s2});
		out_flow.now = now_s2;
	end

endmodule

>>> rtl/core/ldd_cell.sv
// One button cell: decode step, change stamp and debounce for a single button.
module ldd_cell #(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [ldd_pkg::WEIGHT_W-1:0] weight,
	input  logic [ldd_pkg::TOL_W-1:0] tolerance,
	input  logic [ldd_pkg::DEB_W-1:0] debounce_ms,
	input  logic in_valid,
	output logic in_ready,
	input  ldd_pkg::ldd_flow_t in_flow,
	output logic out_valid,
	input  logic out_ready,
	output ldd_pkg::ldd_flow_t out_flow
);
	import ldd_pkg::*;

	localparam logic [MASK_W-1:0] BIT_MASK = MASK_W'(1) << BIT;

	logic raw_q;
	logic stable_q;
	logic [TIME_W-1:0] stamp_q;
	logic valid_q;
	ldd_flow_t flow_q;

	logic take;
	logic signed [LVL_W-1:0] level;
	logic signed [LVL_W-1:0] weight_ext;
	logic signed [LVL_W-1:0] thresh;
	logic released;
	logic raw_new;
	logic [TIME_W-1:0] elapsed;
	logic accept;
	logic stable_new;
	ldd_flow_t flow_next;

	assign in_ready = !valid_q || out_ready;
	assign take = in_valid && in_ready;

	// Signed compare against the weight less the tolerance.
	assign level = in_flow.level;
	assign weight_ext = $signed({{(LVL_W-WEIGHT_W){1'b0}}, weight});
	assign thresh = weight_ext - $signed({{(LVL_W-TOL_W){1'b0}}, tolerance});
	assign released = level > thresh;
	assign raw_new = !released;

	// A change is accepted only when the raw state was already settled before this group.
	assign elapsed = in_flow.now - stamp_q;
	assign accept = (raw_new == raw_q) && (raw_new != stable_q)
		&& (elapsed > TIME_W'(debounce_ms));
	assign stable_new = accept ? raw_new : stable_q;

	always_comb begin
		flow_next = in_flow;
		flow_next.level = released ? (level - weight_ext) : level;
		if (stable_new) begin
			flow_next.held = in_flow.held | BIT_MASK;
		end
		if (accept && raw_new) begin
			flow_next.pressed = in_flow.pressed | BIT_MASK;
		end
		if (accept && !raw_new) begin
			flow_next.released = in_flow.released | BIT_MASK;
		end
	end

	// Button state held by this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= 1'b0;
			stable_q <= 1'b0;
			stamp_q <= '0;
		end else if (take) begin
			raw_q <= raw_new;
			stable_q <= stable_new;
			if (raw_new != raw_q) begin
				stamp_q <= in_flow.now;
			end
		end
	end

	// Output stage towards the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			flow_q <= flow_next;
		end
	end

	assign out_valid = valid_q;
	assign out_flow = flow_q;

endmodule
